[hw/rtl/vbe_pkg.sv]
// Shared constants, command codes and stage payload types of the binarization encoder.
`default_nettype none

package vbe_pkg;

    // Field widths
    localparam int CMD_W      = 3;
    localparam int SYM_IN_W   = 16;
    localparam int PAR_W      = 16;
    localparam int CODE_W     = 64;
    localparam int LEN_W      = 7;
    localparam int VAL_W      = SYM_IN_W + 1;
    localparam int SUM_W      = PAR_W + 2;

    // Default for the symbol mask width
    localparam int SYMBOL_BITS_DEF = 16;

    // Longest codeword and the HEVC escape prefix length
    localparam int MAX_LEN       = 64;
    localparam int ESCAPE_PREFIX = 3;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_EXP_GOLOMB  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RICE        = 3'd1;
    localparam logic [CMD_W-1:0] CMD_HEVC_REM    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UNARY       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TRUNC_UNARY = 3'd4;
    localparam logic [CMD_W-1:0] CMD_BINARY      = 3'd5;

    // Stage 1 result: decoded item with Exp-Golomb base value and Rice quotient
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [SYM_IN_W-1:0] sym;
        logic [PAR_W-1:0]    par;
        logic [VAL_W-1:0]    v;
        logic [SYM_IN_W-1:0] q;
        logic                eg_small;
        logic                esc;
    } front_t;

    // Stage 2 result: codeword layout
    typedef struct packed {
        logic [LEN_W-1:0]    len;
        logic [LEN_W-1:0]    sh;
        logic [LEN_W-1:0]    lsuf;
        logic [SYM_IN_W-1:0] val;
        logic                ovf;
    } layout_t;

endpackage

`default_nettype wire

[hw/rtl/vbe_front.sv]
// Stage 1: symbol masking, Exp-Golomb base value, escape test and Rice quotient.
`default_nettype none

module vbe_front #(
    parameter int SYMBOL_BITS = vbe_pkg::SYMBOL_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [vbe_pkg::CMD_W-1:0]      in_cmd,
    input  wire logic [vbe_pkg::SYM_IN_W-1:0]   in_sym,
    input  wire logic [vbe_pkg::PAR_W-1:0]      in_par,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output vbe_pkg::front_t                     out_data
);
    import vbe_pkg::*;

    localparam int SYM_W = (SYMBOL_BITS < SYM_IN_W) ? SYMBOL_BITS : SYM_IN_W;
    localparam logic [SYM_IN_W-1:0] SYM_MASK = SYM_IN_W'((33'd1 << SYM_W) - 33'd1);

    logic                valid_reg;
    front_t              data_reg;
    front_t              data_next;
    logic [SYM_IN_W-1:0] sym_m;
    logic [VAL_W-1:0]    v_eg;
    logic [VAL_W-1:0]    v_hevc;
    logic [VAL_W-1:0]    thr;

    // Mask symbol, form base values of both Exp-Golomb forms
    always_comb
    begin
        sym_m  = in_sym & SYM_MASK;
        v_eg   = {1'b0, sym_m} + (VAL_W'(1) << in_par);
        thr    = VAL_W'(ESCAPE_PREFIX) << in_par;
        v_hevc = {1'b0, sym_m} - (VAL_W'(1) << (in_par + PAR_W'(1)));

        data_next.cmd      = in_cmd;
        data_next.sym      = sym_m;
        data_next.par      = in_par;
        data_next.q        = sym_m >> in_par;
        data_next.eg_small = (in_par < PAR_W'(SYM_W));
        data_next.esc      = (in_par < PAR_W'(SYM_W - 1)) && ({1'b0, sym_m} >= thr);
        data_next.v        = (in_cmd == CMD_HEVC_REM) ? v_hevc : v_eg;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Advance valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load payload on accept
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/vbe_layout.sv]
// Stage 2: leading-one search, prefix and suffix lengths, overflow test.
`default_nettype none

module vbe_layout (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire vbe_pkg::front_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output vbe_pkg::layout_t     out_data
);
    import vbe_pkg::*;

    localparam int C_W = $clog2(VAL_W);

    logic                valid_reg;
    layout_t             data_reg;
    layout_t             data_next;
    logic [C_W-1:0]      c;
    logic [VAL_W-1:0]    sclr;
    logic [SUM_W-1:0]    pfx;
    logic [SUM_W-1:0]    lsuf;
    logic                z;
    logic [SYM_IN_W-1:0] val;
    logic                force_ovf;
    logic [SUM_W-1:0]    len_full;
    logic                ovf;

    // Find the leading one of the base value and clear it
    always_comb
    begin
        c = '0;
        for (int i = 0; i < VAL_W; i++)
        begin
            if (in_data.v[i])
            begin
                c = C_W'(i);
            end
        end
        sclr = in_data.v & ~(VAL_W'(1) << c);
    end

    // Decode the command into prefix ones, separator and suffix
    always_comb
    begin
        pfx       = '0;
        lsuf      = '0;
        z         = 1'b0;
        val       = '0;
        force_ovf = 1'b0;
        unique case (in_data.cmd)
            CMD_EXP_GOLOMB:
            begin
                z = 1'b1;
                if (in_data.par >= PAR_W'(MAX_LEN))
                begin
                    force_ovf = 1'b1;
                end
                else if (in_data.eg_small)
                begin
                    pfx  = SUM_W'(c) - SUM_W'(in_data.par);
                    lsuf = SUM_W'(c);
                    val  = sclr[SYM_IN_W-1:0];
                end
                else
                begin
                    lsuf = SUM_W'(in_data.par);
                    val  = in_data.sym;
                end
            end
            CMD_RICE:
            begin
                z    = 1'b1;
                pfx  = SUM_W'(in_data.q);
                lsuf = SUM_W'(in_data.par);
                val  = in_data.sym;
            end
            CMD_HEVC_REM:
            begin
                z = 1'b1;
                if (in_data.esc)
                begin
                    pfx  = SUM_W'(ESCAPE_PREFIX) + SUM_W'(c) - SUM_W'(in_data.par);
                    lsuf = SUM_W'(c);
                    val  = sclr[SYM_IN_W-1:0];
                end
                else
                begin
                    pfx  = SUM_W'(in_data.q);
                    lsuf = SUM_W'(in_data.par);
                    val  = in_data.sym;
                end
            end
            CMD_UNARY:
            begin
                z   = 1'b1;
                pfx = SUM_W'(in_data.sym);
            end
            CMD_TRUNC_UNARY:
            begin
                z   = (in_data.sym != in_data.par);
                pfx = SUM_W'(in_data.sym);
            end
            CMD_BINARY:
            begin
                lsuf = SUM_W'(in_data.par);
                val  = in_data.sym;
            end
            default:
            begin
                z = 1'b0;
            end
        endcase
    end

    // Total length and overflow; zero the layout on overflow
    always_comb
    begin
        len_full = pfx + SUM_W'(z) + lsuf;
        ovf      = force_ovf || (len_full > SUM_W'(MAX_LEN));
        if (ovf)
        begin
            data_next.len  = '0;
            data_next.sh   = '0;
            data_next.lsuf = '0;
            data_next.val  = '0;
        end
        else
        begin
            data_next.len  = len_full[LEN_W-1:0];
            data_next.sh   = lsuf[LEN_W-1:0] + LEN_W'(z);
            data_next.lsuf = lsuf[LEN_W-1:0];
            data_next.val  = val;
        end
        data_next.ovf = ovf;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Advance valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load payload on accept
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/vbe_pack.sv]
// Stage 3: codeword assembly from masks, held in the output register.
`default_nettype none

module vbe_pack (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire vbe_pkg::layout_t             in_data,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [vbe_pkg::CODE_W-1:0]        out_code,
    output logic [vbe_pkg::LEN_W-1:0]         out_len,
    output logic                              out_ovf
);
    import vbe_pkg::*;

    logic              valid_reg;
    logic [CODE_W-1:0] code_reg;
    logic [CODE_W-1:0] code_next;
    logic [LEN_W-1:0]  len_reg;
    logic              ovf_reg;

    // Mask of the n lowest bits
    function automatic logic [CODE_W-1:0] low_ones(input logic [LEN_W-1:0] n);
        logic [CODE_W-1:0] m;
        if (n >= LEN_W'(CODE_W))
        begin
            m = '1;
        end
        else
        begin
            m = (CODE_W'(1) << n) - CODE_W'(1);
        end
        return m;
    endfunction

    // Prefix ones above the separator, suffix bits below
    always_comb
    begin
        code_next = (low_ones(in_data.len) ^ low_ones(in_data.sh))
                  | (CODE_W'(in_data.val) & low_ones(in_data.lsuf));
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_code  = code_reg;
    assign out_len   = len_reg;
    assign out_ovf   = ovf_reg;

    // Advance valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load result on accept
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            code_reg <= code_next;
            len_reg  <= in_data.len;
            ovf_reg  <= in_data.ovf;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/vlc_binarization_encoder.sv]
// Top level of the variable-length binarization encoder.
//
// Takes one item per cycle on the slave stream: a command in s_tuser, a
// symbol and a parameter in s_tdata. Gives one result item per input item
// on the master stream: the right-aligned codeword and its length in
// m_tdata and the overflow flag in m_tuser. Commands: Exp-Golomb,
// Golomb-Rice, HEVC coeff_abs_level_remaining, unary, truncated unary and
// fixed-length binary; unused codes give an empty codeword.
// The item passes three register stages (decode and base value, layout and
// overflow, codeword assembly into the output register), and the first of
// them loads at the accepting edge.
// Throughput: one item per cycle sustained while m_tready stays high.
// Reset clears the valid bit of every stage; no item is in flight after it.
// When the receiver holds m_tready low the result stays on the port and
// each stage keeps its item; bubbles fill up, then s_tready drops. Nothing
// is lost or repeated.
`default_nettype none

module vlc_binarization_encoder #(
    parameter int SYMBOL_BITS = vbe_pkg::SYMBOL_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // symbol[15:0], param[31:16]
    input  wire logic [2:0]  s_tuser,   // command[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // code[63:0], code_length[70:64], zero[71]
    output logic             m_tuser    // overflow[0]
);
    import vbe_pkg::*;

    logic              f_valid;
    logic              f_ready;
    front_t            f_data;
    logic              l_valid;
    logic              l_ready;
    layout_t           l_data;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  code_length;

    vbe_front #(
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_sym    (s_tdata[15:0]),
        .in_par    (s_tdata[31:16]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    vbe_layout u_layout (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (l_valid),
        .out_ready (l_ready),
        .out_data  (l_data)
    );

    vbe_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (l_valid),
        .in_ready  (l_ready),
        .in_data   (l_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_code  (code),
        .out_len   (code_length),
        .out_ovf   (m_tuser)
    );

    // Pack result fields
    assign m_tdata = {1'b0, code_length, code};

endmodule

`default_nettype wire

[hw/rtl/vbe_checker.sv]
// Port-level assertions for the binarization encoder and their bind.
`default_nettype none

module vbe_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic        m_tuser
);

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Overflow gives an empty codeword
    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 72'd0)
        else $error("overflow with nonzero code or length");

    // Length stays within the code field
    a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[70:64] <= 7'd64)
        else $error("code length above 64");

    // No code bit above the length
    a_code_fit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[70:64] < 7'd64) |-> (m_tdata[63:0] >> m_tdata[70:64]) == 64'd0)
        else $error("code bits beyond code length");

endmodule

bind vlc_binarization_encoder vbe_checker u_vbe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
